// ===== hw/rtl/mia_pkg.sv =====
package mia_pkg;

  localparam int MAX_DIM = 4;
  localparam int DIM_W   = 2;
  localparam int CNT_W   = 3;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int CELL_W  = 4;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic signed [DATA_W-1:0] FX_ONE = 32'sh0001_0000;

  localparam logic [1:0] OP_TRANSPOSE = 2'd0;
  localparam logic [1:0] OP_DET       = 2'd1;
  localparam logic [1:0] OP_COFACTOR  = 2'd2;
  localparam logic [1:0] OP_INVERSE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SIZE = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_OPERATION = 2'd2;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/mia_if.sv =====
interface mia_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] element_value;
  logic        is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface mia_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output result_value, output out_row, output out_col,
                  output status, output last_result, input ready);
  modport sink   (input valid, input result_value, input out_row, input out_col,
                  input status, input last_result, output ready);
endinterface

// ===== hw/rtl/mia_div.sv =====
// Restoring divider: round(|num| * 2^16 / |den|), ties away from zero, signed and saturated.
module mia_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mia_pkg::div_req_t req,
  output mia_pkg::div_rsp_t rsp
);

  localparam int DVD_W = 49;
  localparam int STEP_W = 6;

  logic              neg_r;
  logic [31:0]       ud_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  q_r;
  logic [31:0]       rem_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [31:0]      abs_num;
  logic [31:0]      abs_den;
  logic [DVD_W-1:0] dvd_init;
  logic [32:0]      trial;
  logic             fits;

  assign abs_num  = req.num[31] ? 32'(-req.num) : 32'(req.num);
  assign abs_den  = req.den[31] ? 32'(-req.den) : 32'(req.den);
  assign dvd_init = {1'b0, abs_num, 16'h0000} + DVD_W'(abs_den >> 1);
  assign trial    = {rem_r, dvd_r[DVD_W-1]};
  assign fits     = trial >= {1'b0, ud_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      neg_r  <= req.num[31] ^ req.den[31];
      ud_r   <= abs_den;
      dvd_r  <= dvd_init;
      rem_r  <= '0;
      q_r    <= '0;
      cnt_r  <= STEP_W'(DVD_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, ud_r}) : trial[31:0];
      q_r   <= {q_r[DVD_W-2:0], fits};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      rsp.quot = (q_r > DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-q_r[31:0]);
    end else begin
      rsp.quot = (q_r > DVD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : q_r[31:0];
    end
  end

endmodule

// ===== hw/rtl/matrix_inverse_adjugate_unit.sv =====
// Q16.16 matrix unit: transpose, determinant, cofactor matrix or inverse of a row_count by
// col_count matrix (up to 4x4) loaded row-major, one element per cycle; the beat flagged
// is_last starts the run and the input stays not ready until the last result is loaded
// into the output register. Minors are built bottom-up over column subsets by a single
// 32x32 multiplier with rounding accumulator: a subset of two or more columns passes a
// mask check, four multiplier slots, a flush and a write-back, and a single column the
// mask check alone. The inverse adds one pass of the shared restoring divider per
// element; a transpose streams one beat per cycle while the output is not stalled.
module matrix_inverse_adjugate_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  mia_in_if.sink                      in_ch,
  mia_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mia_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_PASS_INIT, S_MASK, S_MUL, S_FIN, S_WR, S_PASS_END,
    S_EMIT_ONE, S_EMIT_T, S_EMIT_COF, S_DIV_START, S_DIV_WAIT
  } state_t;

  typedef logic signed [mia_pkg::DATA_W-1:0] word_t;

  function automatic logic [mia_pkg::CELL_W-1:0] cell_idx(
    input logic [mia_pkg::DIM_W-1:0] r,
    input logic [mia_pkg::DIM_W-1:0] c,
    input logic [mia_pkg::CNT_W-1:0] stride);
    logic [5:0] t;
    t = 6'(r) * 6'(stride) + 6'(c);
    return t[mia_pkg::CELL_W-1:0];
  endfunction

  function automatic logic [mia_pkg::CNT_W-1:0] popcnt(input logic [mia_pkg::MAX_DIM-1:0] m);
    logic [mia_pkg::CNT_W-1:0] s;
    s = '0;
    for (int b = 0; b < mia_pkg::MAX_DIM; b++) s = s + mia_pkg::CNT_W'(m[b]);
    return s;
  endfunction

  function automatic logic [mia_pkg::DIM_W-1:0] low_bit(input logic [mia_pkg::MAX_DIM-1:0] m);
    logic [mia_pkg::DIM_W-1:0] k;
    k = '0;
    for (int b = mia_pkg::MAX_DIM - 1; b >= 0; b--) if (m[b]) k = mia_pkg::DIM_W'(b);
    return k;
  endfunction

  function automatic word_t sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7fff_ffff) return 32'sh7fff_ffff;
    if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic word_t neg_sat(input word_t x);
    if (x == 32'sh8000_0000) return 32'sh7fff_ffff;
    return -x;
  endfunction

  // configuration
  logic [mia_pkg::CNT_W-1:0] row_count_r;
  logic [mia_pkg::CNT_W-1:0] col_count_r;
  logic [1:0]                operation_r;
  logic [1:0]                cfg_idx;

  assign cfg_idx    = cfg_paddr[mia_pkg::ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= mia_pkg::CNT_W'(1);
      col_count_r <= mia_pkg::CNT_W'(1);
      operation_r <= mia_pkg::OP_TRANSPOSE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        mia_pkg::REG_ROW_COUNT: row_count_r <= cfg_pwdata[mia_pkg::CNT_W-1:0];
        mia_pkg::REG_COL_COUNT: col_count_r <= cfg_pwdata[mia_pkg::CNT_W-1:0];
        mia_pkg::REG_OPERATION: operation_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mia_pkg::REG_ROW_COUNT: cfg_prdata = 32'(row_count_r);
      mia_pkg::REG_COL_COUNT: cfg_prdata = 32'(col_count_r);
      mia_pkg::REG_OPERATION: cfg_prdata = 32'(operation_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // datapath state
  state_t                      state_r;
  word_t                       mat_r  [mia_pkg::CELLS];
  word_t                       dmin_r [mia_pkg::CELLS];
  word_t                       cof_r  [mia_pkg::CELLS];
  logic [mia_pkg::POS_W-1:0]   load_pos_r;
  logic [mia_pkg::MAX_DIM-1:0] mask_r;
  logic [mia_pkg::DIM_W-1:0]   bit_r;
  logic                        par_r;
  logic [mia_pkg::DIM_W-1:0]   i_r;
  logic [mia_pkg::DIM_W-1:0]   j_r;
  logic                        excl_v_r;
  logic signed [63:0]          acc_r;
  logic signed [63:0]          prod_r;
  logic                        prod_v_r;
  logic                        prod_neg_r;
  word_t                       det_r;
  word_t                       one_val_r;
  logic [1:0]                  one_st_r;

  logic                        out_valid_r;
  word_t                       out_value_r;
  logic [1:0]                  out_row_r;
  logic [1:0]                  out_col_r;
  logic [1:0]                  out_status_r;
  logic                        out_last_r;

  mia_pkg::div_req_t div_req;
  mia_pkg::div_rsp_t div_rsp;

  mia_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // minor sequencing; rows come from the bottom of the row list, skipping the excluded row
  logic [mia_pkg::CNT_W-1:0]   n3;
  logic [mia_pkg::CNT_W-1:0]   m3;
  logic [mia_pkg::MAX_DIM:0]   full_mask;
  logic [mia_pkg::MAX_DIM-1:0] allowed;
  logic [mia_pkg::CNT_W-1:0]   pc;
  logic [mia_pkg::CNT_W-1:0]   rsel;
  logic [mia_pkg::CNT_W-1:0]   row3;
  logic [mia_pkg::DIM_W-1:0]   row_sel;
  logic                        mask_ok;
  logic                        at_target;
  word_t                       single_val;
  word_t                       mul_a;
  word_t                       mul_b;
  logic signed [63:0]          mul_p;
  logic signed [63:0]          term;
  word_t                       pass_val;
  word_t                       cof_val;
  logic                        last_ij;
  logic                        tr_last;
  logic                        bad_size;
  logic                        slot_free;

  assign n3        = row_count_r;
  assign m3        = n3 - mia_pkg::CNT_W'(excl_v_r);
  assign full_mask = ((mia_pkg::MAX_DIM+1)'(1) << n3) - 1'b1;
  assign allowed   = full_mask[mia_pkg::MAX_DIM-1:0]
                   & ~(excl_v_r ? (mia_pkg::MAX_DIM'(1) << j_r) : '0);
  assign pc        = popcnt(mask_r);
  assign rsel      = m3 - pc;
  assign row3      = rsel + mia_pkg::CNT_W'(excl_v_r && (rsel >= mia_pkg::CNT_W'(i_r)));
  assign row_sel   = row3[mia_pkg::DIM_W-1:0];
  assign mask_ok   = ((mask_r & ~allowed) == '0) && (pc <= m3);
  assign at_target = mask_r == allowed;

  assign single_val = mat_r[cell_idx(row_sel, low_bit(mask_r), n3)];
  assign mul_a      = mat_r[cell_idx(row_sel, bit_r, n3)];
  assign mul_b      = dmin_r[mask_r ^ (mia_pkg::MAX_DIM'(1) << bit_r)];
  assign mul_p      = 64'(mul_a) * 64'(mul_b);
  assign term       = (prod_r + 64'sd32768) >>> 16;

  assign pass_val = (m3 == '0) ? mia_pkg::FX_ONE : dmin_r[allowed];
  assign cof_val  = (i_r[0] ^ j_r[0]) ? neg_sat(pass_val) : pass_val;
  assign last_ij  = (mia_pkg::CNT_W'(i_r) == n3 - 1'b1) && (mia_pkg::CNT_W'(j_r) == n3 - 1'b1);
  assign tr_last  = (mia_pkg::CNT_W'(i_r) == col_count_r - 1'b1)
                 && (mia_pkg::CNT_W'(j_r) == row_count_r - 1'b1);
  assign bad_size = (row_count_r == '0) || (col_count_r == '0)
                 || (row_count_r > mia_pkg::CNT_W'(mia_pkg::MAX_DIM))
                 || (col_count_r > mia_pkg::CNT_W'(mia_pkg::MAX_DIM));
  assign slot_free = !out_valid_r || out_ch.ready;

  assign div_req.start = state_r == S_DIV_START;
  assign div_req.num   = cof_r[cell_idx(j_r, i_r, n3)];
  assign div_req.den   = det_r;

  // result beat selection
  logic       emit_go;
  word_t      emit_val;
  logic [1:0] emit_st;
  logic       emit_last;

  always_comb begin
    emit_go   = 1'b0;
    emit_val  = '0;
    emit_st   = mia_pkg::ST_OK;
    emit_last = 1'b0;
    case (state_r)
      S_EMIT_ONE: begin
        emit_go   = slot_free;
        emit_val  = one_val_r;
        emit_st   = one_st_r;
        emit_last = 1'b1;
      end
      S_EMIT_T: begin
        emit_go   = slot_free;
        emit_val  = mat_r[cell_idx(j_r, i_r, col_count_r)];
        emit_last = tr_last;
      end
      S_EMIT_COF: begin
        emit_go   = slot_free;
        emit_val  = cof_r[cell_idx(i_r, j_r, n3)];
        emit_last = last_ij;
      end
      S_DIV_WAIT: begin
        emit_go   = slot_free && div_rsp.done;
        emit_val  = div_rsp.quot;
        emit_last = last_ij;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = state_r == S_IDLE;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.out_row      = out_row_r;
  assign out_ch.out_col      = out_col_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.last_result  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_pos_r  <= '0;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
      excl_v_r    <= 1'b0;
      det_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (emit_go) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= emit_val;
        out_row_r    <= (state_r == S_EMIT_ONE) ? 2'd0 : i_r;
        out_col_r    <= (state_r == S_EMIT_ONE) ? 2'd0 : j_r;
        out_status_r <= emit_st;
        out_last_r   <= emit_last;
      end

      if (prod_v_r) acc_r <= prod_neg_r ? acc_r - term : acc_r + term;

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (load_pos_r < mia_pkg::POS_W'(mia_pkg::CELLS)) begin
              mat_r[load_pos_r[mia_pkg::CELL_W-1:0]] <= in_ch.element_value;
              load_pos_r <= load_pos_r + 1'b1;
            end
            if (in_ch.is_last) begin
              load_pos_r <= '0;
              state_r    <= S_START;
            end
          end
        end
        S_START: begin
          i_r <= '0;
          j_r <= '0;
          if (bad_size) begin
            one_val_r <= '0;
            one_st_r  <= mia_pkg::ST_SIZE;
            state_r   <= S_EMIT_ONE;
          end else if (operation_r == mia_pkg::OP_TRANSPOSE) begin
            state_r <= S_EMIT_T;
          end else if (row_count_r != col_count_r) begin
            one_val_r <= '0;
            one_st_r  <= mia_pkg::ST_CALC;
            state_r   <= S_EMIT_ONE;
          end else begin
            excl_v_r <= 1'b0;
            state_r  <= S_PASS_INIT;
          end
        end
        S_PASS_INIT: begin
          mask_r  <= mia_pkg::MAX_DIM'(1);
          state_r <= (m3 == '0) ? S_PASS_END : S_MASK;
        end
        S_MASK: begin
          if (mask_ok && pc > mia_pkg::CNT_W'(1)) begin
            acc_r   <= '0;
            bit_r   <= '0;
            par_r   <= 1'b0;
            state_r <= S_MUL;
          end else begin
            if (mask_ok) dmin_r[mask_r] <= single_val;
            if (at_target) state_r <= S_PASS_END;
            else mask_r <= mask_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_v_r <= mask_r[bit_r];
          if (mask_r[bit_r]) begin
            prod_r     <= mul_p;
            prod_neg_r <= par_r;
            par_r      <= ~par_r;
          end
          if (bit_r == mia_pkg::DIM_W'(mia_pkg::MAX_DIM - 1)) state_r <= S_FIN;
          else bit_r <= bit_r + 1'b1;
        end
        S_FIN: begin
          prod_v_r <= 1'b0;
          state_r  <= S_WR;
        end
        S_WR: begin
          dmin_r[mask_r] <= sat32(acc_r);
          if (at_target) state_r <= S_PASS_END;
          else begin
            mask_r  <= mask_r + 1'b1;
            state_r <= S_MASK;
          end
        end
        S_PASS_END: begin
          if (!excl_v_r) begin
            det_r <= pass_val;
            if (operation_r == mia_pkg::OP_DET) begin
              one_val_r <= pass_val;
              one_st_r  <= mia_pkg::ST_OK;
              state_r   <= S_EMIT_ONE;
            end else begin
              excl_v_r <= 1'b1;
              state_r  <= S_PASS_INIT;
            end
          end else begin
            cof_r[cell_idx(i_r, j_r, n3)] <= cof_val;
            if (last_ij) begin
              i_r <= '0;
              j_r <= '0;
              if (operation_r == mia_pkg::OP_COFACTOR) state_r <= S_EMIT_COF;
              else if (det_r == '0) begin
                one_val_r <= '0;
                one_st_r  <= mia_pkg::ST_CALC;
                state_r   <= S_EMIT_ONE;
              end else state_r <= S_DIV_START;
            end else begin
              if (mia_pkg::CNT_W'(j_r) == n3 - 1'b1) begin
                j_r <= '0;
                i_r <= i_r + 1'b1;
              end else j_r <= j_r + 1'b1;
              state_r <= S_PASS_INIT;
            end
          end
        end
        S_EMIT_ONE: begin
          if (emit_go) state_r <= S_IDLE;
        end
        S_EMIT_T: begin
          if (emit_go) begin
            if (tr_last) state_r <= S_IDLE;
            else if (mia_pkg::CNT_W'(j_r) == row_count_r - 1'b1) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end
        end
        S_EMIT_COF: begin
          if (emit_go) begin
            if (last_ij) state_r <= S_IDLE;
            else if (mia_pkg::CNT_W'(j_r) == n3 - 1'b1) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end
        end
        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (emit_go) begin
            if (last_ij) state_r <= S_IDLE;
            else begin
              if (mia_pkg::CNT_W'(j_r) == n3 - 1'b1) begin
                j_r <= '0;
                i_r <= i_r + 1'b1;
              end else j_r <= j_r + 1'b1;
              state_r <= S_DIV_START;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mia_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [1:0]         st;
    logic               last;
  } result_beat_t;

  // one directed run: size, op, elements, optional hand-typed single result
  typedef struct packed {
    logic [2:0]        rows;
    logic [2:0]        cols;
    logic [1:0]        op;
    logic [2:0]        count;
    logic [0:5][31:0]  elems;
    logic              typed;
    result_beat_t      typed_res;
  } directed_run_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  mia_in_if  in_ch();
  mia_out_if out_ch();

  matrix_inverse_adjugate_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the block
  int          shadow_mat [CELLS];
  int          shadow_cof [CELLS];
  int          shadow_pos;
  logic [2:0]  shadow_rows = 3'd1;
  logic [2:0]  shadow_cols = 3'd1;
  logic [1:0]  shadow_op = OP_TRANSPOSE;

  result_beat_t matrix_results [$];
  bit           typed_pending;
  result_beat_t typed_beat;
  bit           calm;
  int           mismatches, results_seen, runs_done, elements_sent, idle_cycles;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return int'(x);
  endfunction

  // floor((a*b + half) / 2^16)
  function automatic longint q_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int q_div(int num, int den);
    longint un, ud, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = (num < 0 ? -longint'(num) : longint'(num)) <<< 16;
    ud = den < 0 ? -longint'(den) : longint'(den);
    q = (un + ud / 2) / ud;
    if (neg) return q > 64'sd2147483648 ? 32'h8000_0000 : int'(-q);
    return q > 64'sd2147483647 ? 32'h7fff_ffff : int'(q);
  endfunction

  // minor over row/column subsets, expanded along its lowest-index row
  function automatic int minor_det(int rmask, int cmask, int stride);
    int n, r, k;
    longint acc, term;
    n = $countones(cmask[3:0]);
    acc = 0;
    k = 0;
    r = 0;
    if (n == 0) return FX_ONE;
    while (!rmask[r]) r++;
    for (int c = 0; c < MAX_DIM; c++) begin
      if (cmask[c]) begin
        if (n == 1) return shadow_mat[r * stride + c];
        term = q_mul(shadow_mat[r * stride + c],
                     minor_det(rmask & ~(1 << r), cmask & ~(1 << c), stride));
        acc += k[0] ? -term : term;
        k++;
      end
    end
    return sat32(acc);
  endfunction

  function automatic result_beat_t beat(int v, int r, int c, logic [1:0] st, bit last);
    result_beat_t b;
    b.value = v; b.row = r[1:0]; b.col = c[1:0]; b.st = st; b.last = last;
    return b;
  endfunction

  function automatic void absorb_element(int v, bit last);
    result_beat_t run_out [$];
    int nr, nc, n, full, d, cf;
    if (shadow_pos < CELLS) begin
      shadow_mat[shadow_pos] = v;
      shadow_pos++;
    end
    if (!last) return;
    shadow_pos = 0;
    nr = shadow_rows;
    nc = shadow_cols;
    if (nr == 0 || nc == 0 || nr > MAX_DIM || nc > MAX_DIM) begin
      run_out.push_back(beat(0, 0, 0, ST_SIZE, 1'b1));
    end else if (shadow_op == OP_TRANSPOSE) begin
      for (int i = 0; i < nc; i++)
        for (int j = 0; j < nr; j++)
          run_out.push_back(beat(shadow_mat[j * nc + i], i, j, ST_OK, 1'b0));
    end else if (nr != nc) begin
      run_out.push_back(beat(0, 0, 0, ST_CALC, 1'b1));
    end else begin
      n = nr;
      full = (1 << n) - 1;
      d = minor_det(full, full, n);
      if (shadow_op == OP_DET) begin
        run_out.push_back(beat(d, 0, 0, ST_OK, 1'b1));
      end else begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            cf = minor_det(full & ~(1 << i), full & ~(1 << j), n);
            if ((i + j) % 2 == 1) cf = sat32(-longint'(cf));
            shadow_cof[i * n + j] = cf;
          end
        if (shadow_op == OP_COFACTOR) begin
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
              run_out.push_back(beat(shadow_cof[i * n + j], i, j, ST_OK, 1'b0));
        end else if (d == 0) begin
          run_out.push_back(beat(0, 0, 0, ST_CALC, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
              run_out.push_back(beat(q_div(shadow_cof[j * n + i], d), i, j, ST_OK, 1'b0));
        end
      end
    end
    run_out[run_out.size() - 1].last = 1'b1;
    if (typed_pending) begin
      matrix_results.push_back(typed_beat);
      typed_pending = 0;
    end else begin
      foreach (run_out[i]) matrix_results.push_back(run_out[i]);
    end
    runs_done++;
  endfunction

  // monitor: predict on input beats, compare output beats
  always @(posedge clk) begin
    result_beat_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_element(in_ch.element_value, in_ch.is_last);
        elements_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = beat(out_ch.result_value, out_ch.out_row, out_ch.out_col,
                   out_ch.status, out_ch.last_result);
        results_seen++;
        if (matrix_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat %h", $time, got);
        end else begin
          want = matrix_results.pop_front();
          if (got.value !== want.value)
            $display("%0t: result_value expected %h actual %h", $time, want.value, got.value);
          if (got.row !== want.row)
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
          if (got.col !== want.col)
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, got.col);
          if (got.st !== want.st)
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          if (got.last !== want.last)
            $display("%0t: last_result expected %0d actual %0d", $time, want.last, got.last);
          if (got !== want) mismatches++;
        end
      end
    end
  end

  // result side back-pressure
  int out_stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_stall = calm ? 0 : $urandom_range(0, 11);
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // calm stretches: no gaps on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) calm = !calm;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, matrix_results.size());
      $display("matrix_inverse_adjugate_unit test failed");
      $finish;
    end
  end

  task automatic send_element(int v, bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element_value <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ROW_COUNT: shadow_rows = val[2:0];
      REG_COL_COUNT: shadow_cols = val[2:0];
      REG_OPERATION: shadow_op = val[1:0];
      default: ;
    endcase
  endtask

  task automatic settle_and_configure(logic [2:0] rows, logic [2:0] cols, logic [1:0] op);
    in_ch.valid <= 1'b0;
    // let the monitor take the last beat before looking at the queue
    @(posedge clk);
    while (matrix_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_ROW_COUNT, {29'd0, rows});
    write_reg(REG_COL_COUNT, {29'd0, cols});
    write_reg(REG_OPERATION, {30'd0, op});
  endtask

  function automatic int random_element();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return int'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
    if (pick < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      default: return 0;
    endcase
  endfunction

  task automatic random_run();
    int shape, nr, nc, count;
    int elems [20];
    logic [1:0] op;
    shape = $urandom_range(0, 9);
    op = 2'($urandom_range(0, 3));
    if (shape == 0) begin
      nr = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
      nc = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) begin
        count = nr; nr = nc; nc = count;
      end
      count = $urandom_range(1, 5);
    end else if (shape == 1) begin
      nr = $urandom_range(1, 4);
      do nc = $urandom_range(1, 4); while (nc == nr);
      count = nr * nc;
    end else begin
      nr = $urandom_range(1, 4);
      nc = nr;
      count = nr * nc;
    end
    for (int i = 0; i < 20; i++) elems[i] = random_element();
    // singular: duplicate first row, or zero for 1x1
    if (shape >= 2 && $urandom_range(0, 6) == 0) begin
      if (nr == 1) elems[0] = 0;
      else for (int c = 0; c < nc; c++) elems[nc + c] = elems[c];
    end
    if (shape != 0 && $urandom_range(0, 9) == 0) count = $urandom_range(count, 20);
    settle_and_configure(nr[2:0], nc[2:0], op);
    for (int i = 0; i < count; i++) send_element(elems[i], i == count - 1);
  endtask

  directed_run_t plan [11];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.element_value = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    calm = 0;
    plan[0]  = '{3'd1, 3'd1, OP_TRANSPOSE, 3'd1, {32'h7fff_ffff, 160'd0},
                 1'b1, '{32'h7fff_ffff, 2'd0, 2'd0, ST_OK, 1'b1}};
    plan[1]  = '{3'd1, 3'd1, OP_DET, 3'd1, {32'h8000_0000, 160'd0},
                 1'b1, '{32'h8000_0000, 2'd0, 2'd0, ST_OK, 1'b1}};
    plan[2]  = '{3'd0, 3'd1, OP_DET, 3'd1, {32'h0001_0000, 160'd0},
                 1'b1, '{32'd0, 2'd0, 2'd0, ST_SIZE, 1'b1}};
    plan[3]  = '{3'd4, 3'd7, OP_INVERSE, 3'd1, {32'hffff_ffff, 160'd0},
                 1'b1, '{32'd0, 2'd0, 2'd0, ST_SIZE, 1'b1}};
    plan[4]  = '{3'd1, 3'd2, OP_DET, 3'd2, {32'h0001_0000, 32'h0002_0000, 128'd0},
                 1'b1, '{32'd0, 2'd0, 2'd0, ST_CALC, 1'b1}};
    plan[5]  = '{3'd1, 3'd1, OP_INVERSE, 3'd1, {32'd0, 160'd0},
                 1'b1, '{32'd0, 2'd0, 2'd0, ST_CALC, 1'b1}};
    plan[6]  = '{3'd1, 3'd1, OP_INVERSE, 3'd1, {32'h0002_0000, 160'd0},
                 1'b1, '{32'h0000_8000, 2'd0, 2'd0, ST_OK, 1'b1}};
    // 1x1 cofactor is the empty determinant
    plan[7]  = '{3'd1, 3'd1, OP_COFACTOR, 3'd1, {32'h0005_0000, 160'd0},
                 1'b1, '{32'h0001_0000, 2'd0, 2'd0, ST_OK, 1'b1}};
    plan[8]  = '{3'd2, 3'd2, OP_DET, 3'd4,
                 {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 64'd0},
                 1'b1, '{32'hfffe_0000, 2'd0, 2'd0, ST_OK, 1'b1}};
    plan[9]  = '{3'd2, 3'd2, OP_INVERSE, 3'd4,
                 {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 64'd0},
                 1'b0, '0};
    plan[10] = '{3'd2, 3'd3, OP_TRANSPOSE, 3'd6,
                 {32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_8000,
                  32'h1234_5678, 32'hedcb_a987}, 1'b0, '0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      settle_and_configure(plan[r].rows, plan[r].cols, plan[r].op);
      typed_beat = plan[r].typed_res;
      typed_pending = plan[r].typed;
      for (int i = 0; i < plan[r].count; i++)
        send_element(plan[r].elems[i], i == plan[r].count - 1);
    end

    while (elements_sent < 220) random_run();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (matrix_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d matrix runs, %0d elements loaded, %0d result beats checked",
             runs_done, elements_sent, results_seen);
    $display("shapes 0..7 by 0..7, all four operations, singular and surplus loads");
    if (mismatches == 0 && matrix_results.size() == 0)
      $display("matrix_inverse_adjugate_unit test passed");
    else
      $display("matrix_inverse_adjugate_unit test failed");
    $finish;
  end

endmodule
